// ----- rtl/core/set_assoc_cache_tag_controller_defines.svh -----
// ---------------------------------------------------------------------------
// Set-associative cache tag controller: assertion macros
// Shared property wrappers for the checker that watches the top-level ports.
// ---------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_TAG_CONTROLLER_DEFINES_SVH
`define SET_ASSOC_CACHE_TAG_CONTROLLER_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define SACTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication checked on every rising clock edge outside reset.
`define SACTC_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

// ----- rtl/core/sactc_pkg.sv -----
// ---------------------------------------------------------------------------
// Set-associative cache tag controller package
// Request codes, register indexes, controller states and helper functions.
// ---------------------------------------------------------------------------
package sactc_pkg;

  typedef enum logic [2:0] {
    ACT_READ  = 3'd0,
    ACT_WRITE = 3'd1,
    ACT_FETCH = 3'd2,
    ACT_INVAL = 3'd3,
    ACT_PROBE = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    CFG_WRITE_BACK     = 2'd0,
    CFG_WRITE_ALLOCATE = 2'd1,
    CFG_HIT_LATENCY    = 2'd2,
    CFG_MISS_PENALTY   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } ctrl_state_e;

  localparam int ActionW  = 3;
  localparam int AddrW    = 32;
  localparam int SetOutW  = 6;
  localparam int TagOutW  = 20;
  localparam int LatW     = 16;
  localparam int CfgIdxW  = 2;

  localparam logic        WriteBackRst     = 1'b1;
  localparam logic        WriteAllocateRst = 1'b1;
  localparam logic [15:0] HitLatencyRst    = 16'd1;
  localparam logic [15:0] MissPenaltyRst   = 16'd10;

  function automatic int floor_log2(input int v);
    int n;
    int x;
    n = 0;
    x = v;
    while (x > 1) begin
      x = x >> 1;
      n++;
    end
    return n;
  endfunction

  function automatic int at_least_one(input int v);
    return (v > 1) ? v : 1;
  endfunction

endpackage

// ----- rtl/core/set_assoc_cache_tag_controller.sv -----
// ---------------------------------------------------------------------------
// Set-associative cache tag controller
// Looks up, fills, invalidates and probes tags of one set-associative cache
// with LRU replacement; the set state lives in one synchronous memory.
// ---------------------------------------------------------------------------
// Usage:
// Requests (action, address) enter on the in_valid_i/in_ready_o channel and
// one result per request leaves on the out_valid_o/out_ready_i channel.
// Each request is a read-modify-write of one set row: the accept edge reads the
// set row from the memory, and once the result register is free the lookup
// writes the updated row back and loads the result register. A new request
// is accepted only after the previous one has written its row back, limited
// by the read-modify-write of the single memory port pair on one row.
// The result register is separate from the lookup, so a request is accepted
// while an earlier result still waits. If the receiver stalls, the lookup
// holds its read data until the result register frees up.
// After reset, a clearing pass writes all 2**log2(SET_COUNT) set rows (64 by default)
// of the memory; requests are not accepted during it, while
// configuration writes on cfg_we_i are taken at any time.
// ---------------------------------------------------------------------------
module set_assoc_cache_tag_controller
  import sactc_pkg::*;
#(
  parameter int SET_COUNT  = 64,
  parameter int WAYS       = 4,
  parameter int LINE_BYTES = 64,
  parameter int ADDR_BITS  = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [LatW-1:0]      cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ActionW-1:0]   action_i,
  input  logic [AddrW-1:0]     address_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 hit_o,
  output logic [SetOutW-1:0]   set_idx_o,
  output logic [TagOutW-1:0]   tag_value_o,
  output logic                 filled_o,
  output logic                 evicted_o,
  output logic [AddrW-1:0]     evict_addr_o,
  output logic                 victim_dirty_o,
  output logic                 inval_dirty_o,
  output logic [LatW-1:0]      latency_o
);

  localparam int OffBits = floor_log2(LINE_BYTES);
  localparam int IdxBits = floor_log2(SET_COUNT);
  localparam int Shift   = OffBits + IdxBits;
  localparam int EffAw   = (ADDR_BITS < AddrW) ? ADDR_BITS : AddrW;
  localparam int TagW    = at_least_one(EffAw - Shift);
  localparam int IdxW    = at_least_one(IdxBits);
  localparam int AgeW    = at_least_one($clog2(WAYS));
  localparam int WayW    = AgeW;
  localparam int SetCnt  = 1 << IdxBits;
  localparam int MemDepth = 1 << IdxW;
  localparam logic [AddrW-1:0] AddrMask =
    (ADDR_BITS >= AddrW) ? {AddrW{1'b1}} : AddrW'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [IdxW-1:0] IdxMask = IdxW'((64'd1 << IdxBits) - 64'd1);
  localparam logic [IdxW-1:0] LastSet = IdxW'(SetCnt - 1);
  localparam logic [AgeW-1:0] OldestAge = AgeW'(WAYS - 1);

  typedef struct packed {
    logic            valid;
    logic            dirty;
    logic [AgeW-1:0] age;
    logic [TagW-1:0] tag;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  ctrl_state_e state_q, state_d;

  logic            write_back_q;
  logic            write_allocate_q;
  logic [LatW-1:0] hit_latency_q;
  logic [LatW-1:0] miss_penalty_q;

  logic [IdxW-1:0] clr_cnt_q, clr_cnt_d;

  row_t ram_q [MemDepth];
  row_t rd_q;
  logic            ram_re;
  logic [IdxW-1:0] ram_raddr;
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  row_t            ram_wdata;

  logic [ActionW-1:0] req_act_q;
  logic [AddrW-1:0]   req_addr_q;
  logic [AddrW-1:0]   in_addr_m;
  logic [IdxW-1:0]    in_idx;

  logic [AddrW-1:0] req_tag_full;
  logic [TagW-1:0]  req_tag;
  logic [IdxW-1:0]  req_idx;

  row_t            clear_row;
  row_t            row_new;
  logic [WAYS-1:0] hit_vec;
  logic [WAYS-1:0] free_vec;
  logic [WAYS-1:0] old_vec;
  logic            found;
  logic            free_any;
  logic [WayW-1:0] hit_way;
  logic [WayW-1:0] open_way;
  logic [WayW-1:0] lru_way;
  logic [WayW-1:0] fill_way;
  logic [WayW-1:0] touch_way;
  logic            touch;
  logic [AgeW-1:0] touch_age;
  logic [63:0]     victim_addr;
  logic            advance;
  logic            is_write;

  logic            r_hit;
  logic            r_inst;
  logic            r_evict;
  logic [AddrW-1:0] r_ev_addr;
  logic            r_wb;
  logic            r_dirty;
  logic [LatW-1:0] r_lat;

  logic                 out_valid_q;
  logic                 hit_q;
  logic [SetOutW-1:0]   set_idx_q;
  logic [TagOutW-1:0]   tag_value_q;
  logic                 filled_q;
  logic                 evicted_q;
  logic [AddrW-1:0]     evict_addr_q;
  logic                 victim_dirty_q;
  logic                 inval_dirty_q;
  logic [LatW-1:0]      latency_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_back_q     <= WriteBackRst;
      write_allocate_q <= WriteAllocateRst;
      hit_latency_q    <= HitLatencyRst;
      miss_penalty_q   <= MissPenaltyRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WRITE_BACK:     write_back_q     <= cfg_wdata_i[0];
        CFG_WRITE_ALLOCATE: write_allocate_q <= cfg_wdata_i[0];
        CFG_HIT_LATENCY:    hit_latency_q    <= cfg_wdata_i;
        CFG_MISS_PENALTY:   miss_penalty_q   <= cfg_wdata_i;
        default:            write_back_q     <= write_back_q;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_addr_m  = address_i & AddrMask;
  assign in_idx     = IdxW'(in_addr_m >> OffBits) & IdxMask;

  assign req_tag_full = req_addr_q >> Shift;
  assign req_tag      = TagW'(req_tag_full);
  assign req_idx      = IdxW'(req_addr_q >> OffBits) & IdxMask;
  assign is_write     = (req_act_q == ACT_WRITE);

  // Set memory.
  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      ram_q[ram_waddr] <= ram_wdata;
    end
    if (ram_re) begin
      rd_q <= ram_q[ram_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_act_q  <= action_i;
      req_addr_q <= in_addr_m;
    end
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      clear_row[w].valid = 1'b0;
      clear_row[w].dirty = 1'b0;
      clear_row[w].age   = AgeW'(w);
      clear_row[w].tag   = '0;
      hit_vec[w]  = rd_q[w].valid && (rd_q[w].tag == req_tag);
      free_vec[w] = !rd_q[w].valid;
      old_vec[w]  = (rd_q[w].age == OldestAge);
    end
    found    = |hit_vec;
    free_any = |free_vec;
    hit_way  = '0;
    open_way = '0;
    lru_way  = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WayW'(w);
      end
      if (free_vec[w]) begin
        open_way = WayW'(w);
      end
      if (old_vec[w]) begin
        lru_way = WayW'(w);
      end
    end
    fill_way = free_any ? open_way : lru_way;
  end

  // Row update and result for the request in the lookup stage.
  always_comb begin
    row_new     = rd_q;
    touch       = 1'b0;
    touch_way   = hit_way;
    r_hit       = 1'b0;
    r_inst      = 1'b0;
    r_evict     = 1'b0;
    r_wb        = 1'b0;
    r_dirty     = 1'b0;
    r_lat       = '0;
    r_ev_addr   = '0;
    victim_addr = (64'(rd_q[lru_way].tag) << Shift) | (64'(req_idx) << OffBits);
    case (req_act_q) inside
      ACT_READ, ACT_WRITE, ACT_FETCH: begin
        if (found) begin
          r_hit = 1'b1;
          r_lat = hit_latency_q;
          touch = 1'b1;
          if (is_write && write_back_q) begin
            row_new[hit_way].dirty = 1'b1;
          end
        end else begin
          r_lat = miss_penalty_q;
          if (!is_write || write_allocate_q) begin
            touch     = 1'b1;
            touch_way = fill_way;
            r_inst    = 1'b1;
            if (!free_any) begin
              r_evict   = 1'b1;
              r_ev_addr = victim_addr[AddrW-1:0];
              r_wb      = rd_q[lru_way].dirty;
            end
            row_new[fill_way].valid = 1'b1;
            row_new[fill_way].tag   = req_tag;
            row_new[fill_way].dirty = is_write && write_back_q;
          end
        end
      end
      ACT_INVAL: begin
        if (found) begin
          r_hit   = 1'b1;
          r_dirty = rd_q[hit_way].dirty;
          row_new[hit_way].valid = 1'b0;
          row_new[hit_way].dirty = 1'b0;
        end
      end
      ACT_PROBE: begin
        r_hit = found;
      end
      default: begin
        r_hit = 1'b0;
      end
    endcase
    touch_age = rd_q[touch_way].age;
    if (touch) begin
      for (int w = 0; w < WAYS; w++) begin
        if (rd_q[w].age < touch_age) begin
          row_new[w].age = rd_q[w].age + AgeW'(1);
        end
      end
      row_new[touch_way].age = '0;
    end
  end

  assign advance = (state_q == ST_LOOKUP) && (!out_valid_q || out_ready_i);

  // Controller.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    ram_re    = 1'b0;
    ram_raddr = in_idx;
    ram_we    = 1'b0;
    ram_waddr = req_idx;
    ram_wdata = row_new;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = clear_row;
        clr_cnt_d = clr_cnt_q + IdxW'(1);
        if (clr_cnt_q == LastSet) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          ram_re  = 1'b1;
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (advance) begin
          ram_we  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      hit_q          <= r_hit;
      set_idx_q      <= SetOutW'(req_idx);
      tag_value_q    <= TagOutW'(req_tag_full);
      filled_q       <= r_inst;
      evicted_q      <= r_evict;
      evict_addr_q   <= r_ev_addr;
      victim_dirty_q <= r_wb;
      inval_dirty_q  <= r_dirty;
      latency_q      <= r_lat;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_q;
  assign set_idx_o      = set_idx_q;
  assign tag_value_o    = tag_value_q;
  assign filled_o       = filled_q;
  assign evicted_o      = evicted_q;
  assign evict_addr_o   = evict_addr_q;
  assign victim_dirty_o = victim_dirty_q;
  assign inval_dirty_o  = inval_dirty_q;
  assign latency_o      = latency_q;

endmodule

// ----- rtl/core/sactc_checker.sv -----
// ---------------------------------------------------------------------------
// Set-associative cache tag controller checker
// Port-level properties of the tag controller, bound to the top level.
// ---------------------------------------------------------------------------
`include "set_assoc_cache_tag_controller_defines.svh"

module sactc_checker
  import sactc_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_we_i,
  input logic [CfgIdxW-1:0]   cfg_idx_i,
  input logic [LatW-1:0]      cfg_wdata_i,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic [ActionW-1:0]   action_i,
  input logic [AddrW-1:0]     address_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic                 hit_o,
  input logic [SetOutW-1:0]   set_idx_o,
  input logic [TagOutW-1:0]   tag_value_o,
  input logic                 filled_o,
  input logic                 evicted_o,
  input logic [AddrW-1:0]     evict_addr_o,
  input logic                 victim_dirty_o,
  input logic                 inval_dirty_o,
  input logic [LatW-1:0]      latency_o
);

  `SACTC_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(tag_value_o) && $stable(evict_addr_o), "Stalled result changed.")
  `SACTC_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o, "Request accepted while a lookup was in flight.")
  `SACTC_ASSERT_IMP(a_install_on_miss, out_valid_o && filled_o, !hit_o, "Line installed on a hit.")
  `SACTC_ASSERT_IMP(a_evict_with_fill, out_valid_o && evicted_o, filled_o, "Eviction without a fill.")
  `SACTC_ASSERT_IMP(a_wb_with_evict, out_valid_o && victim_dirty_o, evicted_o, "Writeback without an eviction.")

endmodule

bind set_assoc_cache_tag_controller sactc_checker u_sactc_checker (.*);

// ----- tb/set_assoc_cache_tag_checker.sv -----
// ---------------------------------------------------------------------------
// Set-associative cache tag controller: result checker
// Watches the configuration port and the request and result channels, keeps its own
// copy of the tag, dirty, valid and age state, predicts the outcome of each
// accepted request and compares it field by field with the result returned.
// ---------------------------------------------------------------------------
module set_assoc_cache_tag_checker
  import sactc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [LatW-1:0]      cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [ActionW-1:0]   action_i,
  input  logic [AddrW-1:0]     address_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic                 hit_i,
  input  logic [SetOutW-1:0]   set_idx_i,
  input  logic [TagOutW-1:0]   tag_value_i,
  input  logic                 filled_i,
  input  logic                 evicted_i,
  input  logic [AddrW-1:0]     evict_addr_i,
  input  logic                 victim_dirty_i,
  input  logic                 inval_dirty_i,
  input  logic [LatW-1:0]      latency_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  localparam int NumRows = 1 << SetOutW;
  localparam int NumWays = 4;
  localparam int AgeW    = $clog2(NumWays);
  localparam int OffBits = AddrW - TagOutW - SetOutW;

  typedef struct packed {
    logic               hit;
    logic [SetOutW-1:0] set_idx;
    logic [TagOutW-1:0] tag_value;
    logic               filled;
    logic               evicted;
    logic [AddrW-1:0]   evict_addr;
    logic               victim_dirty;
    logic               inval_dirty;
    logic [LatW-1:0]    latency;
  } access_outcome_t;

  logic               line_valid [NumRows][NumWays];
  logic               line_dirty [NumRows][NumWays];
  logic [TagOutW-1:0] line_tag   [NumRows][NumWays];
  logic [AgeW-1:0]    line_age   [NumRows][NumWays];

  logic               wb_mode;
  logic               alloc_mode;
  logic [LatW-1:0]    hit_lat;
  logic [LatW-1:0]    miss_lat;

  access_outcome_t    outcome_q [$];
  int unsigned        mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic void touch_way(input int row, input int way);
    logic [AgeW-1:0] prior;
    prior = line_age[row][way];
    for (int w = 0; w < NumWays; w++) begin
      if (line_age[row][w] < prior) begin
        line_age[row][w] = line_age[row][w] + 1'b1;
      end
    end
    line_age[row][way] = '0;
  endfunction

  function automatic access_outcome_t predict_tag_access(input logic [ActionW-1:0] act,
                                                         input logic [AddrW-1:0]   addr);
    access_outcome_t    res;
    int                 row;
    int                 way;
    logic               found;
    logic               free_found;
    logic               is_write;
    logic [TagOutW-1:0] tag;
    logic [AgeW-1:0]    oldest;
    res           = '0;
    row           = int'(addr[OffBits +: SetOutW]);
    tag           = addr[AddrW-1 -: TagOutW];
    is_write      = (act == ACT_WRITE);
    found         = 1'b0;
    free_found    = 1'b0;
    way           = 0;
    res.set_idx   = addr[OffBits +: SetOutW];
    res.tag_value = tag;
    for (int w = 0; w < NumWays; w++) begin
      if (!found && line_valid[row][w] && line_tag[row][w] == tag) begin
        found = 1'b1;
        way   = w;
      end
    end
    if (act == ACT_READ || act == ACT_WRITE || act == ACT_FETCH) begin
      if (found) begin
        res.hit     = 1'b1;
        res.latency = hit_lat;
        touch_way(row, way);
        if (is_write && wb_mode) begin
          line_dirty[row][way] = 1'b1;
        end
      end else begin
        res.latency = miss_lat;
        if (!is_write || alloc_mode) begin
          for (int w = 0; w < NumWays; w++) begin
            if (!free_found && !line_valid[row][w]) begin
              free_found = 1'b1;
              way        = w;
            end
          end
          if (!free_found) begin
            oldest = '0;
            way    = 0;
            for (int w = 0; w < NumWays; w++) begin
              if (line_age[row][w] > oldest) begin
                oldest = line_age[row][w];
                way    = w;
              end
            end
            res.evicted      = 1'b1;
            res.evict_addr   = {line_tag[row][way], addr[OffBits +: SetOutW],
                                OffBits'(0)};
            res.victim_dirty = line_dirty[row][way];
          end
          line_valid[row][way] = 1'b1;
          line_tag[row][way]   = tag;
          line_dirty[row][way] = is_write && wb_mode;
          touch_way(row, way);
          res.filled = 1'b1;
        end
      end
    end else if (act == ACT_INVAL) begin
      if (found) begin
        res.hit              = 1'b1;
        res.inval_dirty      = line_dirty[row][way];
        line_valid[row][way] = 1'b0;
        line_dirty[row][way] = 1'b0;
      end
    end else if (act == ACT_PROBE) begin
      res.hit = found;
    end
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [AddrW-1:0] want,
                               input logic [AddrW-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    access_outcome_t want;
    if (!rst_ni) begin
      for (int r = 0; r < NumRows; r++) begin
        for (int w = 0; w < NumWays; w++) begin
          line_valid[r][w] = 1'b0;
          line_dirty[r][w] = 1'b0;
          line_tag[r][w]   = '0;
          line_age[r][w]   = AgeW'(w);
        end
      end
      wb_mode    = WriteBackRst;
      alloc_mode = WriteAllocateRst;
      hit_lat    = HitLatencyRst;
      miss_lat   = MissPenaltyRst;
      outcome_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WRITE_BACK:     wb_mode    = cfg_wdata_i[0];
          CFG_WRITE_ALLOCATE: alloc_mode = cfg_wdata_i[0];
          CFG_HIT_LATENCY:    hit_lat    = cfg_wdata_i;
          CFG_MISS_PENALTY:   miss_lat   = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        outcome_q.push_back(predict_tag_access(action_i, address_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (outcome_q.size() == 0) begin
          $error("Result returned with no request outstanding.");
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          compare_field("hit", want.hit, hit_i);
          compare_field("set_idx", want.set_idx, set_idx_i);
          compare_field("tag_value", want.tag_value, tag_value_i);
          compare_field("filled", want.filled, filled_i);
          compare_field("evicted", want.evicted, evicted_i);
          compare_field("evict_addr", want.evict_addr, evict_addr_i);
          compare_field("victim_dirty", want.victim_dirty, victim_dirty_i);
          compare_field("inval_dirty", want.inval_dirty, inval_dirty_i);
          compare_field("latency", want.latency, latency_i);
        end
      end
      pending_o <= outcome_q.size();
    end
  end

endmodule

// ----- tb/tb_set_assoc_cache_tag_controller.sv -----
// ---------------------------------------------------------------------------
// Set-associative cache tag controller testbench
// Drives directed and random cache requests through five register settings,
// with random idle cycles on both channels, one long result hold-off and
// drain pauses between settings; a separate checker predicts every result.
// ---------------------------------------------------------------------------
module tb_set_assoc_cache_tag_controller
  import sactc_pkg::*;
;

  localparam int OffW       = AddrW - TagOutW - SetOutW;
  localparam int ActMaxCode = (1 << ActionW) - 1;
  localparam int NumPhases  = 5;
  localparam int PhaseItems = 306;
  localparam int HoldCycles = 250;
  localparam int HoldAfter  = 600;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i   = '0;
  logic [LatW-1:0]      cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [ActionW-1:0]   action_i    = ACT_READ;
  logic [AddrW-1:0]     address_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 hit_o;
  logic [SetOutW-1:0]   set_idx_o;
  logic [TagOutW-1:0]   tag_value_o;
  logic                 filled_o;
  logic                 evicted_o;
  logic [AddrW-1:0]     evict_addr_o;
  logic                 victim_dirty_o;
  logic                 inval_dirty_o;
  logic [LatW-1:0]      latency_o;

  int unsigned          fail_count;
  int unsigned          pending_count;
  int unsigned          requests_sent = 0;
  int unsigned          results_taken = 0;
  logic                 calm          = 1'b0;
  logic                 held_off      = 1'b0;
  logic [SetOutW-1:0]   hot_rows [3];
  logic [TagOutW-1:0]   hot_tags [6];

  set_assoc_cache_tag_controller dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .action_i, .address_i,
    .out_valid_o, .out_ready_i, .hit_o, .set_idx_o, .tag_value_o,
    .filled_o, .evicted_o, .evict_addr_o,
    .victim_dirty_o, .inval_dirty_o, .latency_o
  );

  set_assoc_cache_tag_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .action_i, .address_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .hit_i(hit_o), .set_idx_i(set_idx_o), .tag_value_i(tag_value_o),
    .filled_i(filled_o), .evicted_i(evicted_o),
    .evict_addr_i(evict_addr_o), .victim_dirty_i(victim_dirty_o),
    .inval_dirty_i(inval_dirty_o), .latency_i(latency_o),
    .fail_count_o(fail_count), .pending_o(pending_count)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [AddrW-1:0] line_addr(input logic [TagOutW-1:0] tag,
                                                 input logic [SetOutW-1:0] row);
    return {tag, row, OffW'(0)};
  endfunction

  function automatic logic [AddrW-1:0] pick_address();
    logic [TagOutW-1:0] tag;
    logic [SetOutW-1:0] row;
    tag = ($urandom_range(9, 0) < 7) ? hot_tags[$urandom_range(5, 0)] : TagOutW'($urandom);
    row = ($urandom_range(3, 0) != 0) ? hot_rows[$urandom_range(2, 0)] : SetOutW'($urandom);
    return {tag, row, OffW'($urandom)};
  endfunction

  function automatic logic [ActionW-1:0] pick_action();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 28) return ACT_READ;
    if (roll < 56) return ACT_WRITE;
    if (roll < 68) return ACT_FETCH;
    if (roll < 80) return ACT_INVAL;
    if (roll < 94) return ACT_PROBE;
    return ActionW'($urandom_range(ActMaxCode, ACT_PROBE + 1));
  endfunction

  task automatic push_request(input logic [ActionW-1:0] act, input logic [AddrW-1:0] addr);
    while (!calm && $urandom_range(99, 0) < 16) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    address_i  <= addr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    requests_sent++;
  endtask

  task automatic load_settings(input logic wb, input logic wa,
                               input logic [LatW-1:0] hl, input logic [LatW-1:0] mp);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_WRITE_BACK;
    cfg_wdata_i <= {(LatW-1)'($urandom), wb};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_WRITE_ALLOCATE;
    cfg_wdata_i <= {(LatW-1)'($urandom), wa};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_HIT_LATENCY;
    cfg_wdata_i <= hl;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_MISS_PENALTY;
    cfg_wdata_i <= mp;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        results_taken++;
      end
      if (!held_off && results_taken >= HoldAfter) begin
        held_off = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_ready_i <= calm || ($urandom_range(99, 0) >= 16);
    end
  end

  initial begin
    logic            wb;
    logic            wa;
    logic [LatW-1:0] hl;
    logic [LatW-1:0] mp;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0:       begin wb = 1'b1; wa = 1'b1; hl = 16'd1;      mp = 16'd10;     end
        1:       begin wb = 1'b0; wa = 1'b0; hl = '0;         mp = '1;         end
        2:       begin wb = 1'b1; wa = 1'b0; hl = '1;         mp = '0;         end
        3:       begin wb = 1'b0; wa = 1'b1; hl = LatW'($urandom); mp = LatW'($urandom); end
        default: begin wb = 1'b1; wa = 1'b1; hl = LatW'($urandom); mp = LatW'($urandom); end
      endcase
      load_settings(wb, wa, hl, mp);
      foreach (hot_rows[i]) hot_rows[i] = SetOutW'($urandom);
      foreach (hot_tags[i]) hot_tags[i] = TagOutW'($urandom);
      if (ph == 0) begin
        push_request(ACT_READ,  '0);
        push_request(ACT_WRITE, 32'h0000_003F);
        push_request(ACT_READ,  '1);
        push_request(ACT_WRITE, 32'hFFFF_FFC0);
        push_request(ACT_FETCH, line_addr(20'h1, '1));
        push_request(ACT_FETCH, line_addr(20'h2, '1));
        push_request(ACT_READ,  line_addr(20'h3, '1));
        push_request(ACT_READ,  line_addr(20'h4, '1));
        push_request(ACT_PROBE, '1);
        push_request(ACT_PROBE, line_addr(20'h3, '1));
        push_request(ACT_INVAL, '0);
        push_request(ACT_INVAL, '0);
        push_request(ACT_WRITE, '0);
        push_request(ACT_READ,  line_addr(20'h2, '1));
        push_request(ACT_WRITE, line_addr(20'h5, '1));
        push_request(ACT_INVAL, line_addr(20'h5, '1));
        push_request(ActionW'(ACT_PROBE + 1), '1);
        push_request(ActionW'(ActMaxCode - 1), '0);
        push_request(ActionW'(ActMaxCode), AddrW'($urandom));
      end
      for (int n = 0; n < PhaseItems; n++) begin
        calm = (ph == 3) && (n < 200);
        push_request(pick_action(), pick_address());
      end
      calm = 1'b0;
      in_valid_i <= 1'b0;
      wait_drained();
    end
    repeat (8) @(posedge clk_i);
    $display("Run covered %0d requests across %0d register settings; %0d results compared.",
             requests_sent, NumPhases, results_taken);
    $display("Result channel was held off once for %0d cycles with requests still offered.",
             HoldCycles);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
